FILE: hdl/ffp_pkg.sv
// Shared types, character codes and sizes for the FASTA/FASTQ record parser.
// No dependencies; the RTL files refer to it by scoped names, the testbench files import it.
`timescale 1ns / 1ps

package ffp_pkg;

  localparam int LEN_BITS = 16;
  localparam int ID_BITS = 8;
  localparam int TAIL_BITS = 16;

  localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};
  localparam logic [ID_BITS-1:0] ID_MAX = {ID_BITS{1'b1}};

  // result queue depth, power of two
  localparam int FIFO_DEPTH = 4;

  localparam logic [7:0] CH_GT = 8'h3E;
  localparam logic [7:0] CH_AT = 8'h40;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ONE = 8'h31;
  localparam logic [7:0] CH_TWO = 8'h32;
  localparam logic [7:0] CH_PLUS = 8'h2B;

  typedef enum logic [1:0] {
    REG_FASTQ_MODE  = 2'd0,
    REG_CHECK_PAIRS = 2'd1,
    REG_INTERLEAVED = 2'd2,
    REG_STREAM_MATE = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_PREFIX = 3'd0,
    PH_ID     = 3'd1,
    PH_SEQ    = 3'd2,
    PH_PLUS   = 3'd3,
    PH_QUAL   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_PREFIX = 2'd1,
    ERR_PAIR   = 2'd2
  } err_t;

  typedef struct packed {
    logic fastq_mode;
    logic check_pairs;
    logic interleaved;
    logic stream_mate;
  } cfg_t;

  typedef struct packed {
    logic                kind;
    logic [7:0]          seq_byte;
    logic [ID_BITS-1:0]  id_length;
    logic [1:0]          pair_suffix;
    logic [LEN_BITS-1:0] dna_length;
    logic [LEN_BITS-1:0] qual_length;
    logic                mate;
    err_t                error;
    logic [LEN_BITS-1:0] min_length;
    logic [LEN_BITS-1:0] max_length;
    logic                last;
  } result_t;

  // up to two results per byte, both written into the queue in the same cycle
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } push_t;

endpackage

FILE: hdl/ffp_channels.sv
// Handshake channels of the parser: input bytes, results, register writes.
// Depends on ffp_pkg for field widths.
`timescale 1ns / 1ps

interface ffp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;
  modport source (output valid, data_byte, end_of_buffer, input ready);
  modport sink (input valid, data_byte, end_of_buffer, output ready);
endinterface

interface ffp_result_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [7:0]                   seq_byte;
  logic [ffp_pkg::ID_BITS-1:0]  id_length;
  logic [1:0]                   pair_suffix;
  logic [ffp_pkg::LEN_BITS-1:0] dna_length;
  logic [ffp_pkg::LEN_BITS-1:0] qual_length;
  logic                         mate;
  logic [1:0]                   error;
  logic [ffp_pkg::LEN_BITS-1:0] min_length;
  logic [ffp_pkg::LEN_BITS-1:0] max_length;
  logic                         last;
  modport source (output valid, kind, seq_byte, id_length, pair_suffix, dna_length,
                  qual_length, mate, error, min_length, max_length, last,
                  input ready);
  modport sink (input valid, kind, seq_byte, id_length, pair_suffix, dna_length,
                qual_length, mate, error, min_length, max_length, last,
                output ready);
endinterface

interface ffp_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic       data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/ffp_parser.sv
// Input register and record parsing step: one byte in, up to two results out.
// Depends on ffp_pkg.
`timescale 1ns / 1ps

module ffp_parser (
  input  logic            clk,
  input  logic            rst,
  input  ffp_pkg::cfg_t   cfg,
  input  logic            byte_valid,
  output logic            byte_ready,
  input  logic [7:0]      data_byte,
  input  logic            end_of_buffer,
  input  logic            room,
  output ffp_pkg::push_t  push
);

  typedef struct packed {
    ffp_pkg::phase_t                 phase;
    logic                            line_start;
    logic [ffp_pkg::ID_BITS-1:0]     id_count;
    logic [ffp_pkg::TAIL_BITS-1:0]   id_tail;
    logic [ffp_pkg::LEN_BITS-1:0]    seq_count;
    logic [ffp_pkg::LEN_BITS-1:0]    qual_count;
    logic                            mate_now;
    logic [ffp_pkg::LEN_BITS-1:0]    min_seen;
    logic [ffp_pkg::LEN_BITS-1:0]    max_seen;
    logic                            stopped;
  } parse_state_t;

  logic         s1_valid;
  logic [7:0]   s1_byte;
  logic         s1_eob;
  logic         fire;
  parse_state_t st;
  parse_state_t st_next;
  parse_state_t sum_st;
  ffp_pkg::result_t res0;
  ffp_pkg::result_t res1;
  ffp_pkg::result_t tmp;
  logic [1:0]   k;
  logic [7:0]   pre;

  function automatic parse_state_t clear_record(parse_state_t s);
    parse_state_t r;
    r = s;
    r.phase = ffp_pkg::PH_PREFIX;
    r.line_start = 1'b1;
    r.id_count = '0;
    r.id_tail = '0;
    r.seq_count = '0;
    r.qual_count = '0;
    return r;
  endfunction

  // record summary; bad marks a wrong prefix
  function automatic void make_summary(input ffp_pkg::cfg_t c, input parse_state_t s,
                                       input logic bad, output ffp_pkg::result_t r,
                                       output parse_state_t ns);
    logic                        m;
    logic [ffp_pkg::ID_BITS-1:0] idl;
    logic [1:0]                  suf;
    logic [7:0]                  sep;
    logic [7:0]                  dig;
    ffp_pkg::err_t               err;
    m = c.interleaved ? s.mate_now : c.stream_mate;
    ns = s;
    r = '0;
    r.kind = 1'b1;
    idl = s.id_count;
    suf = 2'd0;
    sep = s.id_tail[15:8];
    dig = s.id_tail[7:0];
    err = ffp_pkg::ERR_NONE;
    if (bad) begin
      ns.stopped = 1'b1;
      err = ffp_pkg::ERR_PREFIX;
    end else begin
      if (c.check_pairs && s.id_count > ffp_pkg::ID_BITS'(2)) begin
        if ((sep inside {ffp_pkg::CH_SLASH, ffp_pkg::CH_DOT, ffp_pkg::CH_SPACE}) &&
            (dig inside {ffp_pkg::CH_ONE, ffp_pkg::CH_TWO})) begin
          suf = (dig == ffp_pkg::CH_ONE) ? 2'd1 : 2'd2;
          // saturated length stays put
          if (idl != ffp_pkg::ID_MAX) begin
            idl = idl - ffp_pkg::ID_BITS'(2);
          end
        end
      end
      if (c.check_pairs && (suf != ({1'b0, m} + 2'd1))) begin
        err = ffp_pkg::ERR_PAIR;
      end
      if (s.seq_count != '0) begin
        if (s.seq_count < ns.min_seen) ns.min_seen = s.seq_count;
        if (s.seq_count > ns.max_seen) ns.max_seen = s.seq_count;
      end
      r.id_length = idl;
      r.pair_suffix = suf;
      r.dna_length = s.seq_count;
      r.qual_length = c.fastq_mode ? s.qual_count : '0;
      if (c.interleaved) ns.mate_now = ~s.mate_now;
    end
    r.mate = m;
    r.error = err;
    r.min_length = ns.min_seen;
    r.max_length = ns.max_seen;
    ns = clear_record(ns);
  endfunction

  assign fire = s1_valid && room;
  assign byte_ready = !s1_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_valid && byte_ready) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
    if (byte_valid && byte_ready) begin
      s1_byte <= data_byte;
      s1_eob <= end_of_buffer;
    end
  end

  always_comb begin
    st_next = st;
    sum_st = st;
    k = 2'd0;
    res0 = '0;
    res1 = '0;
    tmp = '0;
    pre = cfg.fastq_mode ? ffp_pkg::CH_AT : ffp_pkg::CH_GT;
    if (!st_next.stopped) begin
      case (st_next.phase)
        ffp_pkg::PH_PREFIX: begin
          st_next = clear_record(st_next);
          if (s1_byte == pre) begin
            st_next.phase = ffp_pkg::PH_ID;
          end else begin
            make_summary(cfg, st_next, 1'b1, tmp, sum_st);
            st_next = sum_st;
            res0 = tmp;
            k = 2'd1;
          end
        end
        ffp_pkg::PH_ID: begin
          if (s1_byte == ffp_pkg::CH_LF) begin
            st_next.phase = ffp_pkg::PH_SEQ;
            st_next.line_start = 1'b1;
          end else begin
            if (st_next.id_count != ffp_pkg::ID_MAX) begin
              st_next.id_count = st_next.id_count + 1'b1;
            end
            st_next.id_tail = {st_next.id_tail[7:0], s1_byte};
          end
        end
        ffp_pkg::PH_SEQ: begin
          if (s1_byte inside {ffp_pkg::CH_GT, ffp_pkg::CH_AT}) begin
            // record ends; this byte opens the next one
            make_summary(cfg, st_next, 1'b0, tmp, sum_st);
            st_next = sum_st;
            res0 = tmp;
            k = 2'd1;
            if (s1_byte == pre) begin
              st_next.phase = ffp_pkg::PH_ID;
            end else begin
              make_summary(cfg, st_next, 1'b1, tmp, sum_st);
              st_next = sum_st;
              res1 = tmp;
              k = 2'd2;
            end
          end else if (cfg.fastq_mode && st_next.line_start &&
                       s1_byte == ffp_pkg::CH_PLUS) begin
            st_next.phase = ffp_pkg::PH_PLUS;
          end else if (s1_byte inside {ffp_pkg::CH_CR, ffp_pkg::CH_LF}) begin
            st_next.line_start = (s1_byte == ffp_pkg::CH_LF);
          end else begin
            res0.seq_byte = s1_byte;
            k = 2'd1;
            if (st_next.seq_count != ffp_pkg::LEN_MAX) begin
              st_next.seq_count = st_next.seq_count + 1'b1;
            end
            st_next.line_start = 1'b0;
          end
        end
        ffp_pkg::PH_PLUS: begin
          if (s1_byte == ffp_pkg::CH_LF) st_next.phase = ffp_pkg::PH_QUAL;
        end
        default: begin
          if (s1_byte == ffp_pkg::CH_LF) begin
            make_summary(cfg, st_next, 1'b0, tmp, sum_st);
            st_next = sum_st;
            res0 = tmp;
            k = 2'd1;
          end else if (st_next.qual_count != ffp_pkg::LEN_MAX) begin
            st_next.qual_count = st_next.qual_count + 1'b1;
          end
        end
      endcase
    end
    if (s1_eob) begin
      if (!st_next.stopped && st_next.phase != ffp_pkg::PH_PREFIX) begin
        make_summary(cfg, st_next, 1'b0, tmp, sum_st);
        st_next = sum_st;
        if (k == 2'd0) res0 = tmp;
        else res1 = tmp;
        k = k + 2'd1;
      end
      st_next.stopped = 1'b0;
      st_next = clear_record(st_next);
      st_next.mate_now = 1'b0;
    end
    if (k == 2'd1) res0.last = 1'b1;
    else if (k == 2'd2) res1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase <= ffp_pkg::PH_PREFIX;
      st.line_start <= 1'b1;
      st.id_count <= '0;
      st.id_tail <= '0;
      st.seq_count <= '0;
      st.qual_count <= '0;
      st.mate_now <= 1'b0;
      st.min_seen <= ffp_pkg::LEN_MAX;
      st.max_seen <= '0;
      st.stopped <= 1'b0;
    end else if (fire) begin
      st <= st_next;
    end
  end

  always_comb begin
    push.count = fire ? k : 2'd0;
    push.res0 = res0;
    push.res1 = res1;
  end

`ifndef SYNTHESIS
  a_stop_at_prefix: assert property (@(posedge clk) disable iff (rst)
    st.stopped |-> st.phase == ffp_pkg::PH_PREFIX)
    else $error("stopped outside prefix phase");
  a_eob_clears: assert property (@(posedge clk) disable iff (rst)
    fire && s1_eob |=> !st.stopped && !st.mate_now && st.phase == ffp_pkg::PH_PREFIX)
    else $error("end of buffer did not reset record state");
  // second result is always a summary; the first may be a sequence byte
  a_pair_shape: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |-> push.res1.kind && !push.res0.last && push.res1.last)
    else $error("bad two-result push");
`endif

endmodule

FILE: hdl/ffp_result_fifo.sv
// Small result queue taking up to two results a cycle, one out per transfer.
// Depends on ffp_pkg.
`timescale 1ns / 1ps

module ffp_result_fifo (
  input  logic             clk,
  input  logic             rst,
  input  ffp_pkg::push_t   push,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output ffp_pkg::result_t out_data
);

  localparam int PTR_BITS = $clog2(ffp_pkg::FIFO_DEPTH);
  localparam int CNT_BITS = PTR_BITS + 1;

  ffp_pkg::result_t      entries [ffp_pkg::FIFO_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr;
  logic [PTR_BITS-1:0]   rd_ptr;
  logic [CNT_BITS-1:0]   count;
  logic [CNT_BITS-1:0]   count_next;
  logic                  pop;

  assign out_valid = (count != '0);
  assign pop = out_valid && out_ready;
  assign out_data = entries[rd_ptr];
  // two free slots needed, since a byte can yield two results
  assign room = (count <= CNT_BITS'(ffp_pkg::FIFO_DEPTH - 2));
  assign count_next = count + CNT_BITS'(push.count) - CNT_BITS'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) entries[wr_ptr] <= push.res0;
    if (push.count == 2'd2) entries[PTR_BITS'(wr_ptr + 1'b1)] <= push.res1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= PTR_BITS'(wr_ptr + PTR_BITS'(push.count));
      rd_ptr <= PTR_BITS'(rd_ptr + PTR_BITS'(pop));
      count <= count_next;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(ffp_pkg::FIFO_DEPTH))
    else $error("result queue overflow");
  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> room)
    else $error("push without room");
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    pop && push.count == 2'd0 |=> count == $past(count) - 1'b1)
    else $error("count did not drop on transfer");
`endif

endmodule

FILE: hdl/fasta_fastq_record_parser.sv
// FASTA/FASTQ record parser top level: register block, parsing stage, result queue.
// A byte waits in the input register until the queue has room; parsing it then
// writes its results into the queue. Throughput is one byte per cycle except while
// the queue holds more than two results, when input stalls; a byte that closes one
// record and opens or ends another yields two results for the four-entry queue.
// Reset (rst, synchronous) clears registers, parse state, extremes and the queue.
`timescale 1ns / 1ps

module fasta_fastq_record_parser (
  input  logic   clk,
  input  logic   rst,
  ffp_byte_if.sink     bytes,
  ffp_result_if.source results,
  ffp_cfg_if.sink      cfg
);

  ffp_pkg::cfg_t    mode_regs;
  ffp_pkg::push_t   push;
  ffp_pkg::result_t head;
  logic             room;

  // register writes always complete in one transfer
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_regs <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        ffp_pkg::REG_FASTQ_MODE:  mode_regs.fastq_mode <= cfg.data;
        ffp_pkg::REG_CHECK_PAIRS: mode_regs.check_pairs <= cfg.data;
        ffp_pkg::REG_INTERLEAVED: mode_regs.interleaved <= cfg.data;
        ffp_pkg::REG_STREAM_MATE: mode_regs.stream_mate <= cfg.data;
        default: ;
      endcase
    end
  end

  // input register plus one parsing step per byte
  ffp_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .cfg           (mode_regs),
    .byte_valid    (bytes.valid),
    .byte_ready    (bytes.ready),
    .data_byte     (bytes.data_byte),
    .end_of_buffer (bytes.end_of_buffer),
    .room          (room),
    .push          (push)
  );

  // output side is decoupled by the queue
  ffp_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_data  (head)
  );

  assign results.kind        = head.kind;
  assign results.seq_byte    = head.seq_byte;
  assign results.id_length   = head.id_length;
  assign results.pair_suffix = head.pair_suffix;
  assign results.dna_length  = head.dna_length;
  assign results.qual_length = head.qual_length;
  assign results.mate        = head.mate;
  assign results.error       = head.error;
  assign results.min_length  = head.min_length;
  assign results.max_length  = head.max_length;
  assign results.last        = head.last;

endmodule

FILE: tb/ffp_parse_checker.sv
// Checker for the FASTA/FASTQ record parser: watches all three channels, predicts results.
// Depends on ffp_pkg and the channel interfaces in ffp_channels.sv.
`timescale 1ns / 1ps

module ffp_parse_checker
  import ffp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  ffp_byte_if   byte_ch,
  ffp_result_if result_ch,
  ffp_cfg_if    cfg_ch,
  output int    fail_count,
  output int    pending
);

  cfg_t                regs;
  phase_t              ph;
  logic                line_start;
  logic [ID_BITS-1:0]  id_cnt;
  logic [TAIL_BITS-1:0] id_tail;
  logic [LEN_BITS-1:0] seq_cnt;
  logic [LEN_BITS-1:0] qual_cnt;
  logic [LEN_BITS-1:0] min_seen;
  logic [LEN_BITS-1:0] max_seen;
  logic                mate_now;
  logic                stopped;

  result_t expected_results[$];
  result_t byte_results[$];
  int      err_cnt = 0;

  function automatic logic cur_mate();
    return regs.interleaved ? mate_now : regs.stream_mate;
  endfunction

  task automatic clear_record();
    ph = PH_PREFIX;
    line_start = 1'b1;
    id_cnt = '0;
    id_tail = '0;
    seq_cnt = '0;
    qual_cnt = '0;
  endtask

  // record summary; a bad prefix halts parsing until end of buffer
  task automatic close_record(input logic bad_prefix);
    result_t            r;
    logic               m;
    logic [1:0]         suf;
    logic [ID_BITS-1:0] idl;
    r = '0;
    m = cur_mate();
    suf = 2'd0;
    r.kind = 1'b1;
    if (bad_prefix) begin
      stopped = 1'b1;
      r.error = ERR_PREFIX;
    end else begin
      idl = id_cnt;
      if (regs.check_pairs && id_cnt > ID_BITS'(2)) begin
        if ((id_tail[15:8] == CH_SLASH || id_tail[15:8] == CH_DOT ||
             id_tail[15:8] == CH_SPACE) &&
            (id_tail[7:0] == CH_ONE || id_tail[7:0] == CH_TWO)) begin
          suf = (id_tail[7:0] == CH_ONE) ? 2'd1 : 2'd2;
          // saturated length is not reduced
          if (idl < ID_MAX) idl = idl - ID_BITS'(2);
        end
      end
      r.error = (regs.check_pairs && suf != ({1'b0, m} + 2'd1)) ? ERR_PAIR : ERR_NONE;
      if (seq_cnt != '0) begin
        if (seq_cnt < min_seen) min_seen = seq_cnt;
        if (seq_cnt > max_seen) max_seen = seq_cnt;
      end
      r.id_length = idl;
      r.pair_suffix = suf;
      r.dna_length = seq_cnt;
      r.qual_length = regs.fastq_mode ? qual_cnt : '0;
      if (regs.interleaved) mate_now = ~mate_now;
    end
    r.mate = m;
    r.min_length = min_seen;
    r.max_length = max_seen;
    byte_results.push_back(r);
    clear_record();
  endtask

  task automatic open_record(input logic [7:0] b);
    clear_record();
    if (b == (regs.fastq_mode ? CH_AT : CH_GT)) ph = PH_ID;
    else close_record(1'b1);
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic eob);
    result_t r;
    byte_results.delete();
    if (!stopped) begin
      case (ph)
        PH_PREFIX: open_record(b);
        PH_ID: begin
          if (b == CH_LF) begin
            ph = PH_SEQ;
            line_start = 1'b1;
          end else begin
            if (id_cnt != ID_MAX) id_cnt = id_cnt + 1'b1;
            id_tail = {id_tail[7:0], b};
          end
        end
        PH_SEQ: begin
          if (b == CH_GT || b == CH_AT) begin
            close_record(1'b0);
            open_record(b);
          end else if (regs.fastq_mode && line_start && b == CH_PLUS) begin
            ph = PH_PLUS;
          end else if (b == CH_CR || b == CH_LF) begin
            line_start = (b == CH_LF);
          end else begin
            r = '0;
            r.seq_byte = b;
            byte_results.push_back(r);
            if (seq_cnt != LEN_MAX) seq_cnt = seq_cnt + 1'b1;
            line_start = 1'b0;
          end
        end
        PH_PLUS: begin
          if (b == CH_LF) ph = PH_QUAL;
        end
        default: begin
          if (b == CH_LF) close_record(1'b0);
          else if (qual_cnt != LEN_MAX) qual_cnt = qual_cnt + 1'b1;
        end
      endcase
    end
    if (eob) begin
      if (!stopped && ph != PH_PREFIX) close_record(1'b0);
      stopped = 1'b0;
      clear_record();
      mate_now = 1'b0;
    end
    if (byte_results.size() > 0) begin
      r = byte_results.pop_back();
      r.last = 1'b1;
      byte_results.push_back(r);
    end
    foreach (byte_results[i]) expected_results.push_back(byte_results[i]);
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      err_cnt++;
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
    end
  endfunction

  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      regs = '0;
      clear_record();
      mate_now = 1'b0;
      min_seen = LEN_MAX;
      max_seen = '0;
      stopped = 1'b0;
      expected_results.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_reg_t'(cfg_ch.index))
          REG_FASTQ_MODE:  regs.fastq_mode = cfg_ch.data;
          REG_CHECK_PAIRS: regs.check_pairs = cfg_ch.data;
          REG_INTERLEAVED: regs.interleaved = cfg_ch.data;
          REG_STREAM_MATE: regs.stream_mate = cfg_ch.data;
          default: ;
        endcase
      end
      // a result can never stem from a byte taken on the same edge
      if (result_ch.valid && result_ch.ready) begin
        if (expected_results.size() == 0) begin
          err_cnt++;
          $error("unexpected result: kind %0d seq_byte %0d", result_ch.kind,
                 result_ch.seq_byte);
        end else begin
          want = expected_results.pop_front();
          check_field("kind", want.kind, result_ch.kind);
          check_field("seq_byte", want.seq_byte, result_ch.seq_byte);
          check_field("id_length", want.id_length, result_ch.id_length);
          check_field("pair_suffix", want.pair_suffix, result_ch.pair_suffix);
          check_field("dna_length", want.dna_length, result_ch.dna_length);
          check_field("qual_length", want.qual_length, result_ch.qual_length);
          check_field("mate", want.mate, result_ch.mate);
          check_field("error", want.error, result_ch.error);
          check_field("min_length", want.min_length, result_ch.min_length);
          check_field("max_length", want.max_length, result_ch.max_length);
          check_field("last", want.last, result_ch.last);
        end
      end
      if (byte_ch.valid && byte_ch.ready)
        parse_byte(byte_ch.data_byte, byte_ch.end_of_buffer);
    end
    pending <= expected_results.size();
    fail_count <= err_cnt;
  end

endmodule

FILE: tb/fasta_fastq_record_parser_tb.sv
// Top of the record parser testbench: clock, reset, stimulus, idling and the verdict.
// Depends on ffp_pkg, ffp_channels.sv, the parser RTL and tb/ffp_parse_checker.sv.
`timescale 1ns / 1ps

module fasta_fastq_record_parser_tb;
  import ffp_pkg::*;

  // quiet cycles (no transfer on any channel) before the run is declared hung
  localparam int STALL_LIMIT = 5000;
  // slack after the last expected result: parse stage plus queue
  localparam int DRAIN_CYCLES = 4;
  // random byte count per idling phase
  localparam int PHASE_ITEMS = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ffp_byte_if   bytes_ch ();
  ffp_result_if results_ch ();
  ffp_cfg_if    cfg_ch ();

  int fail_count;
  int pending;

  int send_idle_pct;
  int recv_idle_pct;
  int sent_count = 0;
  int quiet_cycles = 0;

  logic [7:0] buf_q[$];   // bytes of the buffer under construction
  logic       gen_mate;   // mate the next generated suffix aims at
  cfg_t       cur_cfg;    // last register setting written

  fasta_fastq_record_parser dut (
    .clk    (clk),
    .rst    (rst),
    .bytes  (bytes_ch),
    .results(results_ch),
    .cfg    (cfg_ch)
  );

  ffp_parse_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .byte_ch   (bytes_ch),
    .result_ch (results_ch),
    .cfg_ch    (cfg_ch),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always #4 clk = ~clk;

  // result side: ready drops at random per the current idle rate
  always @(posedge clk) begin
    results_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog: any transfer restarts the count
  always @(posedge clk) begin
    if (rst || (bytes_ch.valid && bytes_ch.ready) ||
        (results_ch.valid && results_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One byte transfer. Valid stays high on return so back-to-back bytes never
  // see valid lowered and raised in the same step; gaps lower it first.
  task automatic send_byte(input logic [7:0] b, input logic eob);
    while ($urandom_range(99) < send_idle_pct) begin
      bytes_ch.valid <= 1'b0;
      @(posedge clk);
    end
    bytes_ch.valid <= 1'b1;
    bytes_ch.data_byte <= b;
    bytes_ch.end_of_buffer <= eob;
    @(posedge clk);
    while (!bytes_ch.ready) @(posedge clk);
    sent_count++;
  endtask

  // Stop sending until every predicted result has been transferred, then let
  // the parse stage settle (a byte with no result may still be in flight).
  task automatic wait_idle();
    bytes_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes all four registers in one burst, only once the block is idle.
  task automatic write_config(input cfg_t c);
    cfg_reg_t idx;
    logic     v;
    wait_idle();
    idx = idx.first();
    do begin
      case (idx)
        REG_FASTQ_MODE:  v = c.fastq_mode;
        REG_CHECK_PAIRS: v = c.check_pairs;
        REG_INTERLEAVED: v = c.interleaved;
        default:         v = c.stream_mate;
      endcase
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx;
      cfg_ch.data <= v;
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      idx = idx.next();
    end while (idx != idx.first());
    cfg_ch.valid <= 1'b0;
    cur_cfg = c;
  endtask

  // Sends buf_q as one buffer; end_of_buffer rides on its final byte.
  task automatic send_buf();
    for (int i = 0; i < buf_q.size(); i++) send_byte(buf_q[i], i == buf_q.size() - 1);
  endtask

  task automatic send_text(input string s);
    buf_q.delete();
    for (int i = 0; i < s.len(); i++) buf_q.push_back(s[i]);
    send_buf();
  endtask

  function automatic logic [7:0] pick(input string s);
    return s[$urandom_range(s.len() - 1)];
  endfunction

  task automatic add_eol(input bit crlf);
    if (crlf) buf_q.push_back(CH_CR);
    buf_q.push_back(CH_LF);
  endtask

  // Appends one record, mostly well formed, under the current setting.
  task automatic add_record(input int id_len, input int seq_len);
    bit         crlf;
    int         width;
    int         col;
    int         qual_len;
    logic [7:0] c;
    crlf = ($urandom_range(3) == 0);
    // prefix: now and then a random byte, which is usually wrong
    if ($urandom_range(99) < 4) c = 8'($urandom_range(255));
    else c = cur_cfg.fastq_mode ? CH_AT : CH_GT;
    buf_q.push_back(c);
    // identifier: any printable byte
    for (int i = 0; i < id_len; i++) buf_q.push_back(8'($urandom_range(32, 126)));
    // mate suffix, mostly the one the pairing check wants
    if ($urandom_range(3) != 0) begin
      buf_q.push_back(pick("/. "));
      if ($urandom_range(99) < 85) buf_q.push_back(CH_ONE + 8'(gen_mate));
      else buf_q.push_back(pick("123"));
    end
    add_eol(crlf);
    // sequence in short lines, with a rare raw byte as noise
    width = $urandom_range(1, 12);
    col = 0;
    for (int i = 0; i < seq_len; i++) begin
      if ($urandom_range(99) == 0) c = 8'($urandom_range(255));
      else c = pick("ACGTNacgtn");
      buf_q.push_back(c);
      col++;
      if (col == width && i != seq_len - 1) begin
        add_eol(crlf);
        col = 0;
      end
    end
    add_eol(crlf);
    // plus and quality lines, sometimes left out
    if (cur_cfg.fastq_mode && $urandom_range(9) != 0) begin
      buf_q.push_back(CH_PLUS);
      repeat ($urandom_range(0, 3)) buf_q.push_back(8'($urandom_range(33, 126)));
      add_eol(crlf);
      qual_len = ($urandom_range(3) == 0) ? $urandom_range(0, 20) : seq_len;
      for (int i = 0; i < qual_len; i++) buf_q.push_back(8'($urandom_range(33, 126)));
      add_eol(crlf);
    end
    if (cur_cfg.interleaved) gen_mate = ~gen_mate;
  endtask

  // One random buffer: records, sometimes cut short or replaced by noise.
  task automatic send_random_buffer(input int n_records);
    int roll;
    int seq_len;
    buf_q.delete();
    gen_mate = cur_cfg.interleaved ? 1'b0 : cur_cfg.stream_mate;
    roll = $urandom_range(99);
    if (roll < 6) begin
      repeat ($urandom_range(1, 20)) buf_q.push_back(8'($urandom_range(255)));
    end else begin
      for (int r = 0; r < n_records; r++) begin
        seq_len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 16);
        add_record($urandom_range(0, 10), seq_len);
      end
      // broken buffer: end_of_buffer lands inside a record
      if (roll < 16) begin
        roll = $urandom_range(buf_q.size() - 1);
        while (buf_q.size() > roll + 1) void'(buf_q.pop_back());
      end
    end
    send_buf();
  endtask

  // Random traffic at one pair of idle rates, several settings in turn.
  task automatic run_phase(input int s_pct, input int r_pct);
    int start;
    int n;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    start = sent_count;
    n = 0;
    while (sent_count - start < PHASE_ITEMS) begin
      if (n == 0) write_config(cfg_t'(4'h0));
      else if (n == 1) write_config(cfg_t'(4'hF));
      else write_config(cfg_t'(4'($urandom_range(15))));
      repeat ($urandom_range(1, 3)) send_random_buffer($urandom_range(1, 4));
      n++;
    end
  endtask

  initial begin
    bytes_ch.valid <= 1'b0;
    bytes_ch.data_byte <= 8'h00;
    bytes_ch.end_of_buffer <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_FASTQ_MODE;
    cfg_ch.data <= 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    cur_cfg = '0;
    gen_mate = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // --- directed, reset setting (FASTA, no pair check) ---
    // CR/LF dropped, '+' is plain sequence in FASTA, '>' mid-sequence closes
    // the record and opens the next, end of buffer closes the last one
    send_text(">a\nA\r\n+>x\nT");
    // wrong prefix on the final byte, top byte value
    buf_q.delete();
    buf_q.push_back(8'hFF);
    send_buf();
    // wrong prefix, then a zero byte that is ignored up to end of buffer
    buf_q.delete();
    buf_q.push_back("X");
    buf_q.push_back(8'h00);
    send_buf();

    // --- directed, FASTQ with interleaved pair check ---
    // plus line right after the identifier, a one-byte quality line, then a
    // record without suffix ended by '@' in its sequence (pair error twice)
    write_config(cfg_t'(4'b1110));
    send_text("@r/1\n+\nI\n@\nG@");

    // --- random: receiver idles more, then sender, then no idling ---
    run_phase(31, 47);
    run_phase(47, 31);
    run_phase(0, 0);

    // --- saturation: identifier length with a suffix that is not stripped ---
    write_config(cfg_t'(4'b0100));
    buf_q.delete();
    buf_q.push_back(CH_GT);
    repeat (300) buf_q.push_back("a");
    buf_q.push_back(CH_SLASH);
    buf_q.push_back(CH_ONE);
    buf_q.push_back(CH_LF);
    repeat (4) buf_q.push_back(pick("ACGT"));
    buf_q.push_back(CH_LF);
    send_buf();

    // everything predicted must arrive; the watchdog catches a shortfall
    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/ffp_pkg.sv
hdl/ffp_channels.sv
hdl/ffp_parser.sv
hdl/ffp_result_fifo.sv
hdl/fasta_fastq_record_parser.sv
tb/ffp_parse_checker.sv
tb/fasta_fastq_record_parser_tb.sv
